@@ rtl/srdz_pkg.sv @@
// Package for the stick radial dead zone: widths, constants and payload types.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package srdz_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SB          = SAMPLE_BITS;
  localparam int DZW         = 16;
  localparam int RADW        = 2 * SB;
  localparam int SQREMW      = SB + 2;
  localparam int NUMW        = SB + DZW;
  localparam int DENW        = SB + DZW;
  localparam int NW          = SB + NUMW;

  localparam logic [SB-1:0]  FULL_SCALE = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0]  MAX_POS    = {1'b0, {(SB-1){1'b1}}};
  localparam logic [DZW:0]   DZ_ONE     = {1'b1, {DZW{1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] stick_x;
    logic signed [SB-1:0] stick_y;
  } sample_t;

  typedef struct packed {
    logic signed [SB-1:0] out_x;
    logic signed [SB-1:0] out_y;
  } result_t;

  // Payload that walks along the square-root cells.
  typedef struct packed {
    logic [RADW-1:0]   rad;
    logic [SQREMW-1:0] rem;
    logic [SB-1:0]     root;
    logic              sign_x;
    logic              sign_y;
    logic [SB-1:0]     mag_x;
    logic [SB-1:0]     mag_y;
  } sq_t;

  // Payload that walks along the divider cells, both axes side by side.
  typedef struct packed {
    logic            in_zone;
    logic            sign_x;
    logic            sign_y;
    logic [DENW-1:0] den;
    logic [SB-1:0]   nlo_x;
    logic [SB-1:0]   nlo_y;
    logic [DENW-1:0] rem_x;
    logic [DENW-1:0] rem_y;
    logic [SB-1:0]   q_x;
    logic [SB-1:0]   q_y;
  } dv_t;

endpackage

`default_nettype wire

@@ rtl/srdz_sqrt_cell.sv @@
// One cell of the square-root chain: settles one root bit per transfer.
// Depends on srdz_pkg for the payload type and widths.
`timescale 1ns / 1ps
`default_nettype none

module srdz_sqrt_cell
  import srdz_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire sq_t  data_i,
  output logic      valid_o,
  output sq_t       data_o
);

  logic [SQREMW+1:0] cand;
  logic [SQREMW+1:0] trial;
  sq_t               data_d;
  logic              valid_q;
  sq_t               data_q;

  always_comb begin
    cand   = {data_i.rem, data_i.rad[RADW-1:RADW-2]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d = data_i;
    data_d.rad = {data_i.rad[RADW-3:0], 2'b00};
    if (cand >= trial) begin
      data_d.rem  = SQREMW'(cand - trial);
      data_d.root = {data_i.root[SB-2:0], 1'b1};
    end else begin
      data_d.rem  = cand[SQREMW-1:0];
      data_d.root = {data_i.root[SB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/srdz_div_cell.sv @@
// One cell of the divider chain: settles one quotient bit for each axis per transfer.
// Depends on srdz_pkg for the payload type and widths.
`timescale 1ns / 1ps
`default_nettype none

module srdz_div_cell
  import srdz_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire dv_t  data_i,
  output logic      valid_o,
  output dv_t       data_o
);

  logic [DENW:0] cand_x;
  logic [DENW:0] cand_y;
  logic [DENW:0] den_ext;
  dv_t           data_d;
  logic          valid_q;
  dv_t           data_q;

  always_comb begin
    cand_x  = {data_i.rem_x, data_i.nlo_x[SB-1]};
    cand_y  = {data_i.rem_y, data_i.nlo_y[SB-1]};
    den_ext = {1'b0, data_i.den};
    data_d  = data_i;
    data_d.nlo_x = {data_i.nlo_x[SB-2:0], 1'b0};
    data_d.nlo_y = {data_i.nlo_y[SB-2:0], 1'b0};
    if (cand_x >= den_ext) begin
      data_d.rem_x = DENW'(cand_x - den_ext);
      data_d.q_x   = {data_i.q_x[SB-2:0], 1'b1};
    end else begin
      data_d.rem_x = cand_x[DENW-1:0];
      data_d.q_x   = {data_i.q_x[SB-2:0], 1'b0};
    end
    if (cand_y >= den_ext) begin
      data_d.rem_y = DENW'(cand_y - den_ext);
      data_d.q_y   = {data_i.q_y[SB-2:0], 1'b1};
    end else begin
      data_d.rem_y = cand_y[DENW-1:0];
      data_d.q_y   = {data_i.q_y[SB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/stick_radial_dead_zone.sv @@
// Top level of the stick radial dead zone: front stages, the two cell chains and output.
// Depends on srdz_pkg, srdz_sqrt_cell and srdz_div_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one stick sample per cycle while the output side keeps up and returns one
// result per sample, in order. A sample passes through the squaring and setup stages, the
// square-root chain, which settles one root bit per cell, the scale and product stages, the
// divider chain, which settles one quotient bit per cell for both axes, and the output stage.
// The whole pipeline holds when a result waits, so input ready falls only while the output
// register is stalled. The dead-zone register is read part way along the pipeline, so write
// it only while no sample is in flight.
module stick_radial_dead_zone
  import srdz_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire sample_t        sample_i,
  output logic                result_valid_o,
  input  wire logic           result_ready_i,
  output result_t             result_o,
  input  wire logic           dz_we_i,
  input  wire logic [DZW-1:0] dz_wdata_i
);

  logic           en;
  logic [DZW-1:0] dz_q;

  logic [SB-1:0]   in_mag_x;
  logic [SB-1:0]   in_mag_y;
  logic            v1_q;
  logic            sign_x1_q;
  logic            sign_y1_q;
  logic [SB-1:0]   mag_x1_q;
  logic [SB-1:0]   mag_y1_q;
  logic [RADW-1:0] sqx_q;
  logic [RADW-1:0] sqy_q;

  logic            sq_v   [SB+1];
  sq_t             sq_s   [SB+1];
  logic            sq0_v_q;
  sq_t             sq0_q;

  logic              pr_v_q;
  logic              pr_inside_q;
  logic              pr_sign_x_q;
  logic              pr_sign_y_q;
  logic [SB-1:0]     pr_mag_x_q;
  logic [SB-1:0]     pr_mag_y_q;
  logic [NUMW-1:0]   pr_num_q;
  logic [DENW-1:0]   pr_den_q;
  logic [SB-1:0]     root;
  logic [SB-1:0]     capped;
  logic              inside_d;
  logic [NUMW-1:0]   num_d;
  logic [DZW+SB:0]   den_full;

  logic            dv_v [SB+1];
  dv_t             dv_s [SB+1];
  logic            dv0_v_q;
  dv_t             dv0_q;
  logic [NW-1:0]   prod_x;
  logic [NW-1:0]   prod_y;

  logic            result_valid_q;
  result_t         result_q;
  result_t         result_d;
  dv_t             dv_end;

  assign en      = !result_valid_q || result_ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= '0;
    end else if (dz_we_i) begin
      dz_q <= dz_wdata_i;
    end
  end

  assign in_mag_x = sample_i.stick_x[SB-1] ? SB'(~sample_i.stick_x + 1'b1) : sample_i.stick_x;
  assign in_mag_y = sample_i.stick_y[SB-1] ? SB'(~sample_i.stick_y + 1'b1) : sample_i.stick_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      sq0_v_q <= 1'b0;
      pr_v_q  <= 1'b0;
      dv0_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= valid_i;
      sq0_v_q <= v1_q;
      pr_v_q  <= sq_v[SB];
      dv0_v_q <= pr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sign_x1_q <= sample_i.stick_x[SB-1];
      sign_y1_q <= sample_i.stick_y[SB-1];
      mag_x1_q  <= in_mag_x;
      mag_y1_q  <= in_mag_y;
      sqx_q     <= in_mag_x * in_mag_x;
      sqy_q     <= in_mag_y * in_mag_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq0_q.rad    <= sqx_q + sqy_q;
      sq0_q.rem    <= '0;
      sq0_q.root   <= '0;
      sq0_q.sign_x <= sign_x1_q;
      sq0_q.sign_y <= sign_y1_q;
      sq0_q.mag_x  <= mag_x1_q;
      sq0_q.mag_y  <= mag_y1_q;
    end
  end

  assign sq_v[0] = sq0_v_q;
  assign sq_s[0] = sq0_q;

  for (genvar i = 0; i < SB; i++) begin : g_sqrt
    srdz_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_s[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_s[i+1])
    );
  end

  always_comb begin
    root     = sq_s[SB].root;
    capped   = (root > FULL_SCALE) ? FULL_SCALE : root;
    inside_d = ({root, {DZW{1'b0}}} <= {1'b0, dz_q, {(SB-1){1'b0}}});
    num_d    = NUMW'({capped, {DZW{1'b0}}} - {1'b0, dz_q, {(SB-1){1'b0}}});
    den_full = (DZ_ONE - {1'b0, dz_q}) * root;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_inside_q <= inside_d;
      pr_sign_x_q <= sq_s[SB].sign_x;
      pr_sign_y_q <= sq_s[SB].sign_y;
      pr_mag_x_q  <= sq_s[SB].mag_x;
      pr_mag_y_q  <= sq_s[SB].mag_y;
      pr_num_q    <= num_d;
      pr_den_q    <= den_full[DENW-1:0];
    end
  end

  assign prod_x = pr_mag_x_q * pr_num_q;
  assign prod_y = pr_mag_y_q * pr_num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q.in_zone <= pr_inside_q;
      dv0_q.sign_x  <= pr_sign_x_q;
      dv0_q.sign_y  <= pr_sign_y_q;
      dv0_q.den     <= pr_den_q;
      dv0_q.nlo_x   <= prod_x[SB-1:0];
      dv0_q.nlo_y   <= prod_y[SB-1:0];
      dv0_q.rem_x   <= prod_x[NW-1:SB];
      dv0_q.rem_y   <= prod_y[NW-1:SB];
      dv0_q.q_x     <= '0;
      dv0_q.q_y     <= '0;
    end
  end

  assign dv_v[0] = dv0_v_q;
  assign dv_s[0] = dv0_q;

  for (genvar i = 0; i < SB; i++) begin : g_div
    srdz_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .data_i  (dv_s[i]),
      .valid_o (dv_v[i+1]),
      .data_o  (dv_s[i+1])
    );
  end

  assign dv_end = dv_s[SB];

  always_comb begin
    if (dv_end.in_zone) begin
      result_d.out_x = '0;
      result_d.out_y = '0;
    end else begin
      if (dv_end.sign_x) begin
        result_d.out_x = SB'(~dv_end.q_x + 1'b1);
      end else begin
        result_d.out_x = dv_end.q_x[SB-1] ? MAX_POS : dv_end.q_x;
      end
      if (dv_end.sign_y) begin
        result_d.out_y = SB'(~dv_end.q_y + 1'b1);
      end else begin
        result_d.out_y = dv_end.q_y[SB-1] ? MAX_POS : dv_end.q_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (en) begin
      result_valid_q <= dv_v[SB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> v1_q)
    else $error("Transferred sample did not enter the first stage.");

  a_root_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[SB] |-> ({1'b0, sq_s[SB].rem} <= {2'b00, sq_s[SB].root, 1'b0}))
    else $error("Square-root remainder exceeds twice the root.");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v[SB] && !dv_end.in_zone) |-> (dv_end.rem_x < dv_end.den && dv_end.rem_y < dv_end.den))
    else $error("Divider remainder not below the divisor.");

  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v[SB] && !dv_end.in_zone) |-> (dv_end.q_x <= FULL_SCALE && dv_end.q_y <= FULL_SCALE))
    else $error("Quotient beyond full deflection.");

endmodule

`default_nettype wire

@@ bench/srdz_result_checker.sv @@
// Checker for the stick radial dead zone: watches both transfer channels and the dead-zone
// write port, predicts each result and compares it field by field. Depends on srdz_pkg.
`timescale 1ns / 1ps

module srdz_result_checker
  import srdz_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sample_valid_i,
  input  logic           sample_ready_i,
  input  sample_t        sample_i,
  input  logic           result_valid_i,
  input  logic           result_ready_i,
  input  result_t        result_i,
  input  logic           dz_we_i,
  input  logic [DZW-1:0] dz_wdata_i,
  output int             fail_count_o,
  output int             pending_o
);

  result_t        expected_results_q[$];
  logic [DZW-1:0] dead_zone_copy = '0;
  int             fails = 0;

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = SB; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic logic [SB-1:0] rescale_axis(input longint v, input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned full;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned neg_q;
    full = 64'd1 << (SB - 1);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag * num) / den;
    if (v < 0) begin
      if (q > full) begin
        q = full;
      end
      neg_q = 64'd0 - q;
      return neg_q[SB-1:0];
    end else begin
      if (q > full - 1) begin
        q = full - 1;
      end
      return q[SB-1:0];
    end
  endfunction

  function automatic result_t dead_zone_result(input sample_t s, input logic [DZW-1:0] dz);
    longint          sx;
    longint          sy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned len;
    longint unsigned full;
    longint unsigned one;
    longint unsigned dzl;
    longint unsigned capped;
    longint unsigned num;
    longint unsigned den;
    result_t         r;
    full = 64'd1 << (SB - 1);
    one = 64'd1 << DZW;
    dzl = dz;
    sx = $signed(s.stick_x);
    sy = $signed(s.stick_y);
    ax = (sx < 0) ? longint'(-sx) : longint'(sx);
    ay = (sy < 0) ? longint'(-sy) : longint'(sy);
    len = floor_root(ax * ax + ay * ay);
    r = '0;
    if (len != 0 && len * one > dzl * full) begin
      capped = (len < full) ? len : full;
      num = capped * one - dzl * full;
      den = (one - dzl) * len;
      r.out_x = rescale_axis(sx, num, den);
      r.out_y = rescale_axis(sy, num, den);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t expected;
    if (rst_ni) begin
      if (sample_valid_i && sample_ready_i) begin
        expected_results_q.insert(expected_results_q.size(),
                                  dead_zone_result(sample_i, dead_zone_copy));
      end
      if (result_valid_i && result_ready_i) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result out_x %0d out_y %0d", $time,
                   $signed(result_i.out_x), $signed(result_i.out_y));
          fails++;
        end else begin
          expected = expected_results_q.pop_front();
          if (result_i.out_x !== expected.out_x) begin
            $display("%0t: out_x expected %0d actual %0d", $time,
                     $signed(expected.out_x), $signed(result_i.out_x));
            fails++;
          end
          if (result_i.out_y !== expected.out_y) begin
            $display("%0t: out_y expected %0d actual %0d", $time,
                     $signed(expected.out_y), $signed(result_i.out_y));
            fails++;
          end
        end
      end
      if (dz_we_i) begin
        dead_zone_copy = dz_wdata_i;
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_results_q.size();
  end

endmodule

@@ bench/stick_radial_dead_zone_test.sv @@
// Testbench top for the stick radial dead zone: clock, reset, stimulus and the verdict.
// Depends on srdz_pkg, stick_radial_dead_zone and srdz_result_checker.
`timescale 1ns / 1ps

module stick_radial_dead_zone_test;
  import srdz_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 11;
  localparam int DRAIN_CYCLES = 2 * SAMPLE_BITS + 25;
  localparam int CYCLE_LIMIT  = 200000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           valid_i = 1'b0;
  logic           ready_o;
  sample_t        sample_i = '0;
  logic           result_valid_o;
  logic           result_ready_i = 1'b0;
  result_t        result_o;
  logic           dz_we_i = 1'b0;
  logic [DZW-1:0] dz_wdata_i = '0;

  int fail_count;
  int pending;
  int sender_idle_pct = 13;
  int receiver_stall_pct = 13;
  int cycle_count = 0;

  always #2 clk_i = ~clk_i;

  stick_radial_dead_zone dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .sample_i      (sample_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .result_o      (result_o),
    .dz_we_i       (dz_we_i),
    .dz_wdata_i    (dz_wdata_i)
  );

  srdz_result_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(valid_i),
    .sample_ready_i(ready_o),
    .sample_i      (sample_i),
    .result_valid_i(result_valid_o),
    .result_ready_i(result_ready_i),
    .result_i      (result_o),
    .dz_we_i       (dz_we_i),
    .dz_wdata_i    (dz_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(negedge clk_i) begin
    result_ready_i = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stick_radial_dead_zone regression: fail");
      $finish;
    end
  end

  function automatic sample_t stick_at(input int x, input int y);
    sample_t s;
    s.stick_x = x[SB-1:0];
    s.stick_y = y[SB-1:0];
    return s;
  endfunction

  function automatic sample_t random_sample(input logic [DZW-1:0] dz);
    int rim;
    int x;
    int y;
    int t;
    rim = int'(dz) >> 1;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        x = $urandom_range(65535) - 32768;
        y = $urandom_range(65535) - 32768;
      end
      4: begin
        x = $urandom_range(1) ? 32767 : -32768;
        y = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 32767 : -32768);
      end
      5: begin
        x = rim + int'($urandom_range(2)) - 1;
        y = int'($urandom_range(2));
      end
      6: begin
        t = (rim * 46341) >>> 16;
        x = t + int'($urandom_range(2)) - 1;
        y = t + int'($urandom_range(2)) - 1;
      end
      7: begin
        x = int'($urandom_range(31)) - 16;
        y = int'($urandom_range(31)) - 16;
      end
      default: begin
        x = int'($urandom_range(32767, 23000));
        y = int'($urandom_range(32767, 23000));
      end
    endcase
    if (x < 0 && x > -32768 && $urandom_range(3) == 0) begin
      x = -x;
    end
    x = (x > 32767) ? 32767 : x;
    y = (y > 32767) ? 32767 : y;
    if ($urandom_range(1)) begin
      x = -x;
    end
    if ($urandom_range(1)) begin
      y = -y;
    end
    if ($urandom_range(1)) begin
      t = x;
      x = y;
      y = t;
    end
    return stick_at(x, y);
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      valid_i = 1'b0;
      sample_i = sample_t'($urandom);
      @(negedge clk_i);
    end
    valid_i = 1'b1;
    sample_i = s;
    do @(posedge clk_i); while (!ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_dead_zone(input logic [DZW-1:0] value);
    valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    dz_we_i = 1'b1;
    dz_wdata_i = value;
    @(negedge clk_i);
    dz_we_i = 1'b0;
  endtask

  initial begin
    logic [DZW-1:0] dz;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_dead_zone(16'd0);
    send_sample(stick_at(0, 0));
    send_sample(stick_at(32767, 0));
    send_sample(stick_at(-32768, 0));
    send_sample(stick_at(0, -32768));
    send_sample(stick_at(-32768, -32768));
    send_sample(stick_at(1, -1));

    // A quarter dead zone puts the rim at a length of 8192.
    set_dead_zone(16'd16384);
    send_sample(stick_at(8192, 0));
    send_sample(stick_at(8193, 0));
    send_sample(stick_at(0, -8192));
    send_sample(stick_at(0, -8193));
    send_sample(stick_at(5793, 5793));
    send_sample(stick_at(5794, -5794));
    send_sample(stick_at(32767, 32767));
    send_sample(stick_at(-32768, 32767));
    send_sample(stick_at(32767, -1));

    // With the largest dead zone only a length of 32768 or more lies outside.
    set_dead_zone(16'd65535);
    send_sample(stick_at(32767, 0));
    send_sample(stick_at(-32768, 0));
    send_sample(stick_at(-32768, -32768));
    send_sample(stick_at(32767, 32767));
    send_sample(stick_at(0, -32767));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: dz = 16'd0;
        1: dz = 16'd65535;
        2: dz = 16'd1;
        3: dz = 16'd65534;
        4: dz = 16'd32768;
        5, 6, 7: dz = 16'($urandom_range(20000));
        default: dz = 16'($urandom_range(65535));
      endcase
      set_dead_zone(dz);
      sender_idle_pct = (p == 5) ? 0 : 13;
      receiver_stall_pct = (p == 5) ? 0 : 13;
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_sample(random_sample(dz));
      end
    end

    valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("stick_radial_dead_zone regression: pass");
    end else begin
      $display("stick_radial_dead_zone regression: fail");
    end
    $finish;
  end

endmodule
